>>> hw/rtl/nnr_pkg.sv
package nnr_pkg;

    localparam int TOL_W  = 24;
    localparam int ITER_W = 10;
    localparam int IN_W   = 24;
    localparam int IDX_W  = 4;
    localparam int MAG_W  = 24;
    localparam int IM_W   = 23;
    localparam int ST_W   = 2;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_IDX  = 2'd1;
    localparam logic [ST_W-1:0] ST_ZERO_DER = 2'd2;

    localparam logic [ITER_W-1:0] ITER_RESET = 10'd1000;
    localparam logic [TOL_W-1:0]  TOL_RESET  = 24'd1;

    localparam int REG_TOL  = 0;
    localparam int REG_ITER = 1;

endpackage

>>> hw/rtl/nnr_divider.sv
// Restoring divider: one quotient bit per cycle.
module nnr_divider #(
    parameter int W = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  dsr_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [W:0]    trial;

    assign trial    = {rem_reg, quo_reg[W-1]};
    assign quotient = quo_reg;
    assign done     = done_reg;

    // Load operands on start, then shift one dividend bit in and try subtracting the divisor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dsr_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                if (trial >= {1'b0, dsr_reg})
                begin
                    rem_reg <= W'(trial - {1'b0, dsr_reg});
                    quo_reg <= {quo_reg[W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial[W-1:0];
                    quo_reg <= {quo_reg[W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

>>> hw/rtl/newton_nth_root_core.sv
// Channel | Signals                                   | Dir
// in      | in_valid, in_stall, radicand, root_index  | in
// out     | out_valid, out_stall, real_part, imag_part, status | out
// cfg     | psel penable pwrite paddr pwdata prdata pready     | APB
// One item at a time. Each Newton iteration runs the multiply state (N-1
// products on one shared multiplier plus the derivative check), two passes
// through the one-bit-a-cycle divider (a/p, then the division by N) and
// the update state.
// in_stall is high from acceptance until the result is taken.
// Reset clears the sequencer and restores register defaults.
// A stalled result holds on the output registers.
module newton_nth_root_core #(
    parameter int MAX_ROOT_INDEX = 8,
    parameter int FRACTION_BITS  = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [nnr_pkg::IN_W-1:0]  radicand,
    input  logic [nnr_pkg::IDX_W-1:0]   root_index,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [nnr_pkg::MAG_W-1:0] real_part,
    output logic [nnr_pkg::IM_W-1:0]    imag_part,
    output logic [nnr_pkg::ST_W-1:0]    status,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    // y and p widths: p saturates at 2^(24+F)
    localparam int PW = 24 + FRACTION_BITS + 1;
    localparam int YW = (FRACTION_BITS > 23 ? FRACTION_BITS : 23) + 2;
    localparam int DW = PW + FRACTION_BITS + 1;
    localparam int MW = YW + nnr_pkg::IDX_W;
    localparam logic [PW-1:0] POW_CAP = PW'(1) << (24 + FRACTION_BITS);
    localparam logic [YW-1:0] FX_ONE  = YW'(1) << FRACTION_BITS;
    localparam logic [YW-1:0] Y_CAP   = (FRACTION_BITS > 23) ? FX_ONE : (YW'(1) << 23);
    localparam logic [YW-1:0] MAG_LIM = YW'(1) << 23;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_DIV, S_WAIT, S_DIVN, S_WAITN, S_UPD, S_OUT
    } state_t;

    state_t state_reg;
    logic [nnr_pkg::TOL_W-1:0]  tol_reg;
    logic [nnr_pkg::ITER_W-1:0] maxit_reg;
    logic [nnr_pkg::ITER_W-1:0] it_reg;
    logic [nnr_pkg::IDX_W-1:0]  n_reg;
    logic [nnr_pkg::IDX_W-1:0]  k_reg;
    logic [23:0]  mag_reg;
    logic         neg_reg;
    logic [YW-1:0] y_reg;
    logic [PW-1:0] p_reg;
    logic [DW-1:0] q_reg;
    logic signed [nnr_pkg::MAG_W-1:0] re_reg;
    logic [nnr_pkg::IM_W-1:0] im_reg;
    logic [nnr_pkg::ST_W-1:0] st_reg;

    logic                  div_start;
    logic                  div_done;
    logic [DW-1:0]         div_q;
    logic [DW-1:0]         div_dividend;
    logic [DW-1:0]         div_divisor;
    logic [PW+YW-1:0]      prod;
    logic [MW-1:0]         ymul;
    logic [DW-1:0]         num;
    logic [YW-1:0]         nxt;
    logic [YW-1:0]         diff;
    logic [23:0]           rmag;

    assign pready   = 1'b1;
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign real_part = re_reg;
    assign imag_part = im_reg;
    assign status    = st_reg;

    // Read back configuration
    always_comb
    begin
        case (paddr[2])
            1'(nnr_pkg::REG_TOL): prdata = 32'(tol_reg);
            default:              prdata = 32'(maxit_reg);
        endcase
    end

    assign rmag    = radicand[23] ? 24'(-radicand) : 24'(radicand);
    assign prod    = p_reg * (PW+YW)'(y_reg);

    // Newton update: ((N-1)*y + q) / N, the division by N runs on the shared divider
    assign ymul     = MW'(y_reg) * MW'(n_reg - 1'b1);
    assign num      = q_reg + DW'(ymul);
    assign nxt      = (q_reg > DW'(Y_CAP)) ? Y_CAP : YW'(q_reg);
    assign diff     = (nxt > y_reg) ? nxt - y_reg : y_reg - nxt;

    // Share the divider between a/p and the division by N
    assign div_start    = (state_reg == S_DIV) || (state_reg == S_DIVN);
    assign div_dividend = (state_reg == S_DIVN) ? num : (DW'(mag_reg) << FRACTION_BITS);
    assign div_divisor  = (state_reg == S_DIVN) ? DW'(n_reg) : DW'(p_reg);

    nnr_divider #(.W(DW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // Sequencer, configuration and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tol_reg   <= nnr_pkg::TOL_RESET;
            maxit_reg <= nnr_pkg::ITER_RESET;
        end
        else
        begin
            if (psel && penable && pwrite)
            begin
                if (paddr[2] == 1'(nnr_pkg::REG_TOL))
                    tol_reg <= pwdata[nnr_pkg::TOL_W-1:0];
                else
                    maxit_reg <= pwdata[nnr_pkg::ITER_W-1:0];
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        mag_reg <= rmag;
                        neg_reg <= radicand[23];
                        n_reg   <= root_index;
                        y_reg   <= (YW'(rmag) > FX_ONE) ? YW'(rmag) : FX_ONE;
                        p_reg   <= PW'(FX_ONE);
                        k_reg   <= 4'd1;
                        it_reg  <= '0;
                        if (root_index == '0 || 32'(root_index) > MAX_ROOT_INDEX)
                        begin
                            re_reg    <= '0;
                            im_reg    <= '0;
                            st_reg    <= nnr_pkg::ST_BAD_IDX;
                            state_reg <= S_OUT;
                        end
                        else if (maxit_reg == '0)
                            state_reg <= S_UPD;
                        else
                            state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    if (k_reg >= n_reg)
                    begin
                        if (p_reg == '0)
                        begin
                            re_reg    <= '0;
                            im_reg    <= '0;
                            st_reg    <= nnr_pkg::ST_ZERO_DER;
                            state_reg <= S_OUT;
                        end
                        else
                            state_reg <= S_DIV;
                    end
                    else
                    begin
                        if (prod > (PW+YW)'(POW_CAP))
                            p_reg <= POW_CAP;
                        else
                            p_reg <= PW'(prod >> FRACTION_BITS);
                        k_reg <= k_reg + 1'b1;
                    end
                end
                S_DIV:  state_reg <= S_WAIT;
                S_WAIT:
                begin
                    if (div_done)
                    begin
                        q_reg     <= div_q;
                        state_reg <= S_DIVN;
                    end
                end
                S_DIVN: state_reg <= S_WAITN;
                S_WAITN:
                begin
                    if (div_done)
                    begin
                        q_reg     <= div_q;
                        state_reg <= S_UPD;
                    end
                end
                S_UPD:
                begin
                    if (it_reg < maxit_reg && !(diff == '0 ||
                        diff < YW'(tol_reg)) && maxit_reg != '0)
                    begin
                        y_reg     <= nxt;
                        it_reg    <= it_reg + 1'b1;
                        p_reg     <= PW'(FX_ONE);
                        k_reg     <= 4'd1;
                        state_reg <= (it_reg + 1'b1 < maxit_reg) ? S_MUL : S_UPD;
                        if (it_reg + 1'b1 >= maxit_reg)
                            q_reg <= '0;
                    end
                    else
                    begin
                        st_reg <= nnr_pkg::ST_OK;
                        if (neg_reg && !n_reg[0])
                        begin
                            re_reg <= '0;
                            im_reg <= (y_reg >= MAG_LIM) ? 23'h7FFFFF : 23'(y_reg);
                        end
                        else if (neg_reg)
                        begin
                            im_reg <= '0;
                            re_reg <= (y_reg >= MAG_LIM) ? 24'h800000 : 24'(-y_reg);
                        end
                        else
                        begin
                            im_reg <= '0;
                            re_reg <= (y_reg >= MAG_LIM) ? 24'h7FFFFF : 24'(y_reg);
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_stall)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Busy while a result is pending
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("accepting while result pending");
    // Result held while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status))
        else $error("result dropped");
    // Status code range
    a_st: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == nnr_pkg::ST_OK || status == nnr_pkg::ST_BAD_IDX ||
        status == nnr_pkg::ST_ZERO_DER)) else $error("bad status");

endmodule
